// ===== rtl/swrl_pkg.sv =====
package swrl_pkg;

  // default geometry
  localparam int KEYS_DEF  = 64;
  localparam int SLOTS_DEF = 8;

  // fixed field widths
  localparam int CMD_W     = 2;
  localparam int KEY_IDX_W = 6;
  localparam int TIME_W    = 32;
  localparam int MAX_W     = 4;
  localparam int WIN_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 16;

  // command codes
  localparam logic [CMD_W-1:0] CMD_RECORD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW       = 1'd1;

  // control state, one-hot
  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

endpackage

// ===== rtl/sliding_window_rate_limiter_core.sv =====
// Sliding-log rate limiter. Each key owns one row of SLOTS timestamps plus a
// row of valid bits, held in two single-port synchronous memories. The accept
// edge issues the row read; in the evaluation state the row is evaluated,
// written back and the result register loaded, and the next item can be
// accepted in the cycle after that, not before. A result may wait in the
// output register while the next item is taken; evaluation then holds until
// the result is taken. After reset the valid memory is swept clear, one row
// per cycle, during which no item is accepted; configuration writes are
// taken at any time. key_index is reduced modulo KEYS; a stamp counts as
// live while stamp + window_seconds > now_seconds; a zero limit or window
// disables blocking.
module sliding_window_rate_limiter_core
  import swrl_pkg::*;
#(
  parameter int KEYS  = KEYS_DEF,
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CMD_W-1:0]     in_command,
  input  logic [KEY_IDX_W-1:0] in_key_index,
  input  logic [TIME_W-1:0]    in_now_seconds,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_blocked,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int KW   = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam int SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW   = $clog2(SLOTS + 1);
  localparam int CMPW = (CW > MAX_W) ? CW : MAX_W;
  localparam int KMAP = 1 << KEY_IDX_W;

  // memories
  logic [SLOTS-1:0][TIME_W-1:0] stamp_mem [KEYS];
  logic [SLOTS-1:0]             valid_mem [KEYS];

  state_t                       state_r, state_nxt;
  logic [KW-1:0]                clr_cnt_r, clr_cnt_nxt;
  logic [MAX_W-1:0]             max_r;
  logic [WIN_W-1:0]             win_r;
  logic [CMD_W-1:0]             cmd_r;
  logic [KW-1:0]                key_r;
  logic [TIME_W-1:0]            now_r;
  logic [SLOTS-1:0][TIME_W-1:0] stamp_rd_r;
  logic [SLOTS-1:0]             valid_rd_r;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_blocked_r;

  logic [KW-1:0]                key_map [KMAP];
  logic [KW-1:0]                in_key;
  logic                         in_fire;
  logic                         exec_fire;
  logic                         enabled;
  logic [SLOTS-1:0]             live;
  logic [CW-1:0]                live_cnt;
  logic                         row_full;
  logic [SW-1:0]                free_slot;
  logic                         at_limit;
  logic                         blocked;
  logic                         stamp_we;
  logic [SLOTS-1:0][TIME_W-1:0] stamp_wr;
  logic                         valid_we;
  logic [KW-1:0]                valid_addr;
  logic [SLOTS-1:0]             valid_wr;

  // key index reduced modulo KEYS, table built at elaboration
  for (genvar g = 0; g < KMAP; g++) begin : g_key_map
    assign key_map[g] = KW'(g % KEYS);
  end
  assign in_key = key_map[in_key_index];

  // handshake
  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign exec_fire = (state_r == ST_EXEC) && (!out_valid_r || out_ready);
  assign out_valid   = out_valid_r;
  assign out_blocked = out_blocked_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= '0;
      win_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_ATTEMPTS: max_r <= cfg_data[MAX_W-1:0];
        CFG_WINDOW:       win_r <= cfg_data[WIN_W-1:0];
        default:          ;
      endcase
    end
  end

  // live stamps of the row
  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      live[s] = valid_rd_r[s] &&
                (({1'b0, stamp_rd_r[s]} + {{(TIME_W + 1 - WIN_W){1'b0}}, win_r}) >
                 {1'b0, now_r});
    end
  end

  assign live_cnt = CW'($countones(live));
  assign row_full = &live;

  // lowest free slot
  always_comb begin
    free_slot = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (!live[s]) free_slot = SW'(s);
    end
  end

  assign enabled  = (max_r != '0) && (win_r != '0);
  assign at_limit = CMPW'(live_cnt) >= CMPW'(max_r);

  // per-command result and write-back
  always_comb begin
    blocked  = 1'b0;
    stamp_we = 1'b0;
    valid_we = 1'b0;
    valid_wr = valid_rd_r;
    stamp_wr = stamp_rd_r;
    case (cmd_r)
      CMD_RECORD: begin
        if (enabled) begin
          valid_we = 1'b1;
          valid_wr = live;
          if (at_limit || row_full) begin
            blocked = 1'b1;
          end else begin
            stamp_we            = 1'b1;
            valid_wr[free_slot] = 1'b1;
            stamp_wr[free_slot] = now_r;
          end
        end
      end
      CMD_QUERY: begin
        blocked = enabled && at_limit;
      end
      CMD_CLEAR: begin
        valid_we = 1'b1;
        valid_wr = '0;
      end
      default: ;
    endcase
  end

  // valid memory port: sweep after reset, else row write-back
  assign valid_addr = (state_r == ST_CLEAR) ? clr_cnt_r : key_r;

  always_ff @(posedge clk) begin
    if (state_r == ST_CLEAR) begin
      valid_mem[valid_addr] <= '0;
    end else if (exec_fire && valid_we) begin
      valid_mem[valid_addr] <= valid_wr;
    end
    if (in_fire) begin
      valid_rd_r <= valid_mem[in_key];
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire && stamp_we) begin
      stamp_mem[key_r] <= stamp_wr;
    end
    if (in_fire) begin
      stamp_rd_r <= stamp_mem[in_key];
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= in_command;
      key_r <= in_key;
      now_r <= in_now_seconds;
    end
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == KW'(KEYS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (exec_fire) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec_fire) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) out_blocked_r <= blocked;
  end

  // checks
  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ST_EXEC)
    else $error("accepted beat did not move to evaluation");

  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EXEC))
    else $error("result appeared without evaluation");

  a_store_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire && stamp_we |-> enabled && !at_limit && !row_full && !blocked)
    else $error("stamp stored at or over the limit");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC || state_r == ST_CLEAR) |-> !in_ready)
    else $error("input taken while busy");

endmodule

// ===== tb/rate_limit_checker.sv =====
`timescale 1ns / 1ps

module rate_limit_checker
  import swrl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [CMD_W-1:0]     in_command,
  input  logic [KEY_IDX_W-1:0] in_key_index,
  input  logic [TIME_W-1:0]    in_now_seconds,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 out_blocked,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  output int                   mismatches,
  output int                   awaiting
);

  // one expected answer plus the item it belongs to, for the log
  typedef struct {
    logic                 blocked;
    logic [CMD_W-1:0]     cmd;
    logic [KEY_IDX_W-1:0] key;
    logic [TIME_W-1:0]    now;
  } answer_t;

  answer_t answers_due[$];

  // shadow of the per-key stamp rows and the two limit registers
  logic [TIME_W-1:0] stamp_tab  [KEYS_DEF*SLOTS_DEF];
  logic              stamp_held [KEYS_DEF*SLOTS_DEF];
  logic [MAX_W-1:0]  limit_reg;
  logic [WIN_W-1:0]  window_reg;
  int                errs;

  // a stamp stays live while stamp + window > now, with no wrap
  function automatic logic still_live(input logic [TIME_W-1:0] stamp,
                                      input logic [TIME_W-1:0] now);
    logic [TIME_W:0] reach;
    reach = {1'b0, stamp} + {{(TIME_W + 1 - WIN_W){1'b0}}, window_reg};
    return reach > {1'b0, now};
  endfunction

  // apply one item to the shadow rows and return the blocked answer
  function automatic logic limit_step(input logic [CMD_W-1:0]     cmd,
                                      input logic [KEY_IDX_W-1:0] key,
                                      input logic [TIME_W-1:0]    now);
    int   row;
    int   live;
    int   spare;
    logic armed;
    logic hit;
    row   = (int'(key) % KEYS_DEF) * SLOTS_DEF;
    armed = (limit_reg != 0) && (window_reg != 0);
    hit   = 1'b0;
    live  = 0;
    spare = SLOTS_DEF;
    case (cmd)
      CMD_RECORD: begin
        if (armed) begin
          // drop expired stamps, count the rest, find the first free slot
          for (int s = 0; s < SLOTS_DEF; s++) begin
            if (stamp_held[row+s] && !still_live(stamp_tab[row+s], now))
              stamp_held[row+s] = 1'b0;
            if (stamp_held[row+s])
              live++;
            else if (spare == SLOTS_DEF)
              spare = s;
          end
          // at the limit or with a full row the attempt is refused
          if (live >= limit_reg || spare == SLOTS_DEF) begin
            hit = 1'b1;
          end else begin
            stamp_tab[row+spare]  = now;
            stamp_held[row+spare] = 1'b1;
          end
        end
      end
      CMD_QUERY: begin
        if (armed) begin
          for (int s = 0; s < SLOTS_DEF; s++)
            if (stamp_held[row+s] && still_live(stamp_tab[row+s], now))
              live++;
          hit = (live >= limit_reg);
        end
      end
      CMD_CLEAR: begin
        for (int s = 0; s < SLOTS_DEF; s++)
          stamp_held[row+s] = 1'b0;
      end
      default: ;
    endcase
    return hit;
  endfunction

  always @(posedge clk) begin : watch
    answer_t head;
    answer_t fresh;
    if (!rst_n) begin
      for (int i = 0; i < KEYS_DEF*SLOTS_DEF; i++)
        stamp_held[i] = 1'b0;
      limit_reg  = '0;
      window_reg = '0;
      errs       = 0;
      answers_due.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_ATTEMPTS: limit_reg  = cfg_data[MAX_W-1:0];
          CFG_WINDOW:       window_reg = cfg_data[WIN_W-1:0];
          default: ;
        endcase
      end
      // result beat against the oldest expectation
      if (out_valid && out_ready) begin
        if (answers_due.size() == 0) begin
          $display("%0t: result beat with nothing expected: expected none, actual blocked=%b",
                   $time, out_blocked);
          errs++;
        end else begin
          head = answers_due.pop_front();
          if (out_blocked !== head.blocked) begin
            $display("%0t: cmd %0d key %0d now %0d: expected blocked=%b, actual %b",
                     $time, head.cmd, head.key, head.now, head.blocked, out_blocked);
            errs++;
          end
        end
      end
      // input beat: predict its answer
      if (in_valid && in_ready) begin
        fresh.cmd     = in_command;
        fresh.key     = in_key_index;
        fresh.now     = in_now_seconds;
        fresh.blocked = limit_step(in_command, in_key_index, in_now_seconds);
        answers_due.push_back(fresh);
      end
    end
    mismatches <= errs;
    awaiting   <= answers_due.size();
  end

endmodule

// ===== tb/sliding_window_rate_limiter_core_test.sv =====
`timescale 1ns / 1ps

module sliding_window_rate_limiter_core_test;
  import swrl_pkg::*;

  // command code with no function in the block
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 500000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [CMD_W-1:0]     in_command;
  logic [KEY_IDX_W-1:0] in_key_index;
  logic [TIME_W-1:0]    in_now_seconds;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_blocked;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  int                   mismatches;
  int                   awaiting;
  int                   cycles;
  int                   burst_left;
  int                   hold_asked;
  int                   hold_seen;
  int                   stall_left;
  int                   mode_left;
  int                   rx_mode;
  logic [TIME_W-1:0]    clock_now;

  sliding_window_rate_limiter_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_key_index   (in_key_index),
    .in_now_seconds (in_now_seconds),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_blocked    (out_blocked),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  rate_limit_checker limit_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_key_index   (in_key_index),
    .in_now_seconds (in_now_seconds),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_blocked    (out_blocked),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .awaiting       (awaiting)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("** sliding_window_rate_limiter_core: FAILED **");
      $finish;
    end
  end

  // result side: random stall modes, plus long hold-offs on request
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (hold_seen != hold_asked) begin
      hold_seen  = hold_asked;
      stall_left = 150;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 120);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // write both limit registers on consecutive cycles
  task automatic set_limits(input logic [MAX_W-1:0] lim, input logic [WIN_W-1:0] win);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAX_ATTEMPTS;
    cfg_data  <= CFG_DAT_W'(lim);
    @(posedge clk);
    cfg_index <= CFG_WINDOW;
    cfg_data  <= win;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // present one beat and hold it until taken, then maybe leave a gap
  task automatic offer(input logic [CMD_W-1:0] cmd, input logic [KEY_IDX_W-1:0] key,
                       input logic [TIME_W-1:0] now);
    int gap;
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_key_index   <= key;
    in_now_seconds <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // stop sending and wait until every answer is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // mostly a few hot keys so rows fill up, sometimes any key
  function automatic logic [KEY_IDX_W-1:0] pick_key();
    if ($urandom_range(0, 9) < 7) begin
      case ($urandom_range(0, 3))
        0:       return 6'd0;
        1:       return 6'd21;
        2:       return 6'd42;
        default: return 6'd63;
      endcase
    end
    return KEY_IDX_W'($urandom_range(0, 63));
  endfunction

  // one random phase under a fixed limit setting
  task automatic run_phase(input logic [MAX_W-1:0] lim, input logic [WIN_W-1:0] win,
                           input int items, input logic [TIME_W-1:0] start, input bit hold);
    int               r;
    int               stride;
    logic [CMD_W-1:0] cmd;
    set_limits(lim, win);
    clock_now = start;
    stride    = win / 3 + 1;
    if (hold)
      hold_asked++;
    repeat (items) begin
      // time mostly creeps forward, now and then jumps or steps back
      r = $urandom_range(0, 99);
      if (r < 45)
        ;
      else if (r < 88)
        clock_now += $urandom_range(1, stride);
      else if (r < 95)
        clock_now += $urandom_range(0, 3 * win + 3);
      else if (r < 98)
        clock_now -= $urandom_range(1, win + 1);
      else
        clock_now = $urandom();
      r = $urandom_range(0, 99);
      if (r < 62)
        cmd = CMD_RECORD;
      else if (r < 89)
        cmd = CMD_QUERY;
      else if (r < 96)
        cmd = CMD_CLEAR;
      else
        cmd = CMD_NONE;
      offer(cmd, pick_key(), clock_now);
    end
    drain();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_command     = CMD_RECORD;
    in_key_index   = '0;
    in_now_seconds = '0;
    out_ready      = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_MAX_ATTEMPTS;
    cfg_data       = '0;
    cycles         = 0;
    burst_left     = 0;
    hold_asked     = 0;
    hold_seen      = 0;
    stall_left     = 0;
    mode_left      = 0;
    rx_mode        = 0;
    clock_now      = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // basic limit of three in a ten second window
    set_limits(4'd3, 16'd10);
    offer(CMD_QUERY, 6'd5, 32'd100);
    offer(CMD_RECORD, 6'd5, 32'd100);
    offer(CMD_RECORD, 6'd5, 32'd101);
    offer(CMD_RECORD, 6'd5, 32'd102);
    offer(CMD_RECORD, 6'd5, 32'd103);
    offer(CMD_QUERY, 6'd5, 32'd103);
    // oldest stamp has expired
    offer(CMD_RECORD, 6'd5, 32'd110);
    // time going backwards keeps every stamp live
    offer(CMD_RECORD, 6'd5, 32'd50);
    offer(CMD_CLEAR, 6'd5, 32'd50);
    offer(CMD_QUERY, 6'd5, 32'd50);
    offer(CMD_NONE, 6'd5, 32'd50);
    // stamp plus window past the top of the time range
    offer(CMD_RECORD, 6'd63, 32'hFFFF_FFFF);
    offer(CMD_QUERY, 6'd63, 32'hFFFF_FFFF);
    offer(CMD_RECORD, 6'd0, 32'd0);
    drain();

    // limit above the row size: the ninth record finds the row full
    set_limits(4'd15, 16'd20);
    repeat (9) offer(CMD_RECORD, 6'd7, 32'd200);
    offer(CMD_QUERY, 6'd7, 32'd220);
    drain();

    // zero limit disables blocking, clear still works
    set_limits(4'd0, 16'd10);
    offer(CMD_RECORD, 6'd7, 32'd300);
    offer(CMD_QUERY, 6'd7, 32'd300);
    offer(CMD_CLEAR, 6'd7, 32'd300);
    drain();

    run_phase(4'd4, 16'd50, 160, 32'd1000, 1'b0);
    run_phase(4'd8, 16'hFFFF, 160, 32'hFFFF_0000, 1'b1);
    run_phase(4'd15, 16'd20, 160, $urandom(), 1'b0);
    run_phase(4'd1, 16'd1, 160, 32'd7, 1'b0);
    run_phase(4'd0, 16'd100, 160, 32'h8000_0000, 1'b0);
    run_phase(4'd6, 16'd0, 160, 32'h1234_5678, 1'b0);
    run_phase(4'd2, 16'd7, 160, $urandom(), 1'b1);
    run_phase(MAX_W'($urandom_range(1, 8)), WIN_W'($urandom_range(1, 300)), 160,
              $urandom(), 1'b0);

    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("** sliding_window_rate_limiter_core: PASSED **");
    else
      $display("** sliding_window_rate_limiter_core: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/swrl_pkg.sv
rtl/sliding_window_rate_limiter_core.sv
tb/rate_limit_checker.sv
tb/sliding_window_rate_limiter_core_test.sv
